>>> rtl/core/amc_pkg.sv
package amc_pkg;

  // Word memory geometry; the depth is a power of two so addresses wrap by truncation
  localparam int MEM_DEPTH = 2048;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);
  localparam int WORD_W    = 32;
  localparam int IN_ADDR_W = 11;
  localparam int PC_OUT_W  = 11;
  localparam int CMD_W     = 2;

  // Host commands
  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE   = 2'd0,
    CMD_EXEC    = 2'd1,
    CMD_RESTART = 2'd2
  } cmd_t;

  // Opcodes, each a full word
  localparam logic [WORD_W-1:0] OP_CLR    = 32'd2147483600;
  localparam logic [WORD_W-1:0] OP_ADD    = 32'd2147483599;
  localparam logic [WORD_W-1:0] OP_MUL    = 32'd2147483598;
  localparam logic [WORD_W-1:0] OP_BNZ    = 32'd2147483597;
  localparam logic [WORD_W-1:0] OP_OUTPUT = 32'd2147483596;
  localparam logic [WORD_W-1:0] OP_HALT   = 32'd2147483595;
  localparam logic [WORD_W-1:0] OP_SUB    = 32'd2147483594;
  localparam logic [WORD_W-1:0] OP_NOP    = 32'd2147483593;
  localparam logic [WORD_W-1:0] OP_LOAD   = 32'd2147483592;
  localparam logic [WORD_W-1:0] OP_AD     = 32'd2147483591;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_OP,
    S_OPND,
    S_DATA,
    S_DONE
  } state_t;

  // Reduce a word to a memory index (modulo the depth)
  function automatic logic [ADDR_W-1:0] mem_idx(input logic [WORD_W-1:0] w);
    mem_idx = w[ADDR_W-1:0];
  endfunction

endpackage

>>> rtl/core/amc_if.sv
interface amc_in_if import amc_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic [CMD_W-1:0]            cmd;
  logic [IN_ADDR_W-1:0]        address;
  logic signed [WORD_W-1:0]    data;

  modport source (output valid, output cmd, output address, output data, input ready);
  modport sink   (input valid, input cmd, input address, input data, output ready);
endinterface

interface amc_out_if import amc_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic                        printed;
  logic signed [WORD_W-1:0]    acc_value;
  logic [PC_OUT_W-1:0]         prog_counter;
  logic                        halted;
  logic                        illegal;

  modport source (output valid, output printed, output acc_value, output prog_counter,
                  output halted, output illegal, input ready);
  modport sink   (input valid, input printed, input acc_value, input prog_counter,
                  input halted, input illegal, output ready);
endinterface

>>> rtl/core/amc_word_mem.sv
module amc_word_mem import amc_pkg::*; (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [WORD_W-1:0] wdata,
  output logic [WORD_W-1:0] rdata
);

  logic [WORD_W-1:0] mem [MEM_DEPTH];
  logic [WORD_W-1:0] rdata_r;

  // Single port: registered read, plus a write when we is set (the read returns the old word)
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/core/accumulator_machine_core.sv
// Each beat is accepted in S_IDLE; its result loads into the output register from S_DONE.
// Write, restart, unused command and execute-while-halted go straight to S_DONE; CLR,
// NOP, OUTPUT, HALT and unknown opcodes pass S_OP; ADD, SUB, MUL, BNZ pass S_OP, S_OPND;
// LOAD and AD pass S_OP, S_OPND, S_DATA, as the single memory port reads opcode, operand
// and datum in turn. One item at a time: the next beat is taken after the result loads.
// Synchronous active-low reset clears pc, accumulator, halt flag and the output beat;
// memory contents are undefined until written.
module accumulator_machine_core import amc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  amc_in_if.sink     in_ch,
  amc_out_if.source  out_ch
);

  state_t            state_r, state_nxt;
  logic [WORD_W-1:0] acc_r, acc_nxt;
  logic [ADDR_W-1:0] pc_r, pc_nxt;
  logic              halted_r, halted_nxt;
  logic              printed_r, printed_nxt;
  logic              illegal_r, illegal_nxt;
  logic [WORD_W-1:0] op_r, op_nxt;

  logic                 out_valid_r;
  logic                 out_printed_r;
  logic [WORD_W-1:0]    out_acc_r;
  logic [PC_OUT_W-1:0]  out_pc_r;
  logic                 out_halted_r;
  logic                 out_illegal_r;
  logic                 out_load;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_addr;
  logic [WORD_W-1:0] mem_wdata;
  logic [WORD_W-1:0] mem_rdata;

  amc_word_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // Sequencer: fetch opcode, operand and datum through the one memory port
  always_comb begin
    state_nxt   = state_r;
    acc_nxt     = acc_r;
    pc_nxt      = pc_r;
    halted_nxt  = halted_r;
    printed_nxt = printed_r;
    illegal_nxt = illegal_r;
    op_nxt      = op_r;
    mem_we      = 1'b0;
    mem_addr    = pc_r;
    mem_wdata   = $unsigned(in_ch.data);
    out_load    = 1'b0;
    in_ch.ready = (state_r == S_IDLE);

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          printed_nxt = 1'b0;
          illegal_nxt = 1'b0;
          state_nxt   = S_DONE;
          unique case (cmd_t'(in_ch.cmd))
            CMD_WRITE: begin
              mem_we   = 1'b1;
              mem_addr = mem_idx(WORD_W'(in_ch.address));
            end
            CMD_RESTART: begin
              pc_nxt     = '0;
              acc_nxt    = '0;
              halted_nxt = 1'b0;
            end
            CMD_EXEC: begin
              // Opcode read at pc is already issued on the port
              if (!halted_r) begin
                state_nxt = S_OP;
              end
            end
            default: ;
          endcase
        end
      end

      S_OP: begin
        op_nxt    = mem_rdata;
        mem_addr  = pc_r + ADDR_W'(1);
        state_nxt = S_DONE;
        unique case (mem_rdata)
          OP_CLR: begin
            acc_nxt = '0;
            pc_nxt  = pc_r + ADDR_W'(1);
          end
          OP_NOP: begin
            pc_nxt = pc_r + ADDR_W'(1);
          end
          OP_OUTPUT: begin
            printed_nxt = 1'b1;
            pc_nxt      = pc_r + ADDR_W'(1);
          end
          OP_HALT: begin
            halted_nxt = 1'b1;
          end
          OP_ADD, OP_SUB, OP_MUL, OP_BNZ, OP_LOAD, OP_AD: begin
            state_nxt = S_OPND;
          end
          default: begin
            illegal_nxt = 1'b1;
          end
        endcase
      end

      S_OPND: begin
        // Operand on the read port; its index feeds the datum read
        mem_addr  = mem_idx(mem_rdata);
        pc_nxt    = pc_r + ADDR_W'(2);
        state_nxt = S_DONE;
        unique case (op_r)
          OP_ADD: acc_nxt = acc_r + mem_rdata;
          OP_SUB: acc_nxt = acc_r - mem_rdata;
          OP_MUL: acc_nxt = acc_r * mem_rdata;
          OP_BNZ: begin
            if (acc_r != '0) begin
              pc_nxt = mem_idx(mem_rdata);
            end
          end
          OP_LOAD, OP_AD: begin
            pc_nxt    = pc_r;
            state_nxt = S_DATA;
          end
          default: ;
        endcase
      end

      S_DATA: begin
        pc_nxt    = pc_r + ADDR_W'(2);
        state_nxt = S_DONE;
        if (op_r == OP_LOAD) begin
          acc_nxt = mem_rdata;
        end else begin
          acc_nxt = acc_r + mem_rdata;
        end
      end

      S_DONE: begin
        // Hold until the output register is free
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Machine state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      acc_r     <= '0;
      pc_r      <= '0;
      halted_r  <= 1'b0;
      printed_r <= 1'b0;
      illegal_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      acc_r     <= acc_nxt;
      pc_r      <= pc_nxt;
      halted_r  <= halted_nxt;
      printed_r <= printed_nxt;
      illegal_r <= illegal_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt;
  end

  // Output beat register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_printed_r <= printed_r;
      out_acc_r     <= acc_r;
      out_pc_r      <= PC_OUT_W'(pc_r);
      out_halted_r  <= halted_r;
      out_illegal_r <= illegal_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.printed      = out_printed_r;
  assign out_ch.acc_value    = $signed(out_acc_r);
  assign out_ch.prog_counter = out_pc_r;
  assign out_ch.halted       = out_halted_r;
  assign out_ch.illegal      = out_illegal_r;

  // Memory writes only come straight from an accepted write beat
  a_we_on_write: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (in_ch.valid && in_ch.ready && in_ch.cmd == CMD_WRITE))
    else $error("memory write outside a write beat");

  // An execute while halted leaves pc and accumulator alone
  a_halt_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.cmd == CMD_EXEC && halted_r)
    |=> (pc_r == $past(pc_r) && acc_r == $past(acc_r)))
    else $error("halted machine changed state");

  // A step never both prints and flags an illegal opcode
  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_printed_r && out_illegal_r))
    else $error("printed and illegal both set");

  // An illegal opcode never moves the pc
  a_illegal_pc: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OP && illegal_nxt) |=> (pc_r == $past(pc_r)))
    else $error("pc moved on illegal opcode");

  // The output register is only loaded when free or draining
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_valid_r || out_ch.ready))
    else $error("output beat overwritten");

endmodule

>>> test/tb_top.sv
module tb_top;
  import amc_pkg::*;

  localparam int ITEM_TARGET  = 1050;
  localparam int QUIET_TAIL   = 150;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 10;

  localparam logic [CMD_W-1:0]  CMD_UNUSED    = 2'd3;
  localparam logic [WORD_W-1:0] ILLEGAL_ABOVE = OP_CLR + 32'd1;
  localparam logic [WORD_W-1:0] ILLEGAL_BELOW = OP_AD - 32'd1;

  typedef struct packed {
    logic                printed;
    logic [WORD_W-1:0]   acc_value;
    logic [PC_OUT_W-1:0] prog_counter;
    logic                halted;
    logic                illegal;
  } machine_state_t;

  // Shadow copy of the machine: memory, pc, accumulator, halt flag
  class acc_machine_mirror;
    logic [WORD_W-1:0] mem [MEM_DEPTH];
    bit                written [MEM_DEPTH];
    logic [ADDR_W-1:0] pc;
    logic [WORD_W-1:0] acc;
    bit                stopped;
    machine_state_t    pending_states [$];
    int                errors;

    function new();
      pc      = '0;
      acc     = '0;
      stopped = 1'b0;
      errors  = 0;
      foreach (written[i]) written[i] = 1'b0;
    endfunction

    // Advance the shadow machine by one accepted beat and queue the state it leaves
    function void note_item(logic [CMD_W-1:0] cmd, logic [IN_ADDR_W-1:0] address,
                            logic [WORD_W-1:0] data);
      machine_state_t    st;
      logic [WORD_W-1:0] op;
      logic [WORD_W-1:0] opnd;
      logic [ADDR_W-1:0] next1;
      logic [ADDR_W-1:0] next2;
      st = '0;
      if (cmd == CMD_WRITE) begin
        mem[address]     = data;
        written[address] = 1'b1;
      end else if (cmd == CMD_RESTART) begin
        pc      = '0;
        acc     = '0;
        stopped = 1'b0;
      end else if (cmd == CMD_EXEC && !stopped) begin
        next1 = pc + 1'b1;
        next2 = pc + 2'd2;
        op    = mem[pc];
        opnd  = mem[next1];
        case (op)
          OP_CLR: begin
            acc = '0;
            pc  = next1;
          end
          OP_NOP: pc = next1;
          OP_OUTPUT: begin
            st.printed = 1'b1;
            pc         = next1;
          end
          OP_HALT: stopped = 1'b1;
          OP_ADD: begin
            acc = acc + opnd;
            pc  = next2;
          end
          OP_SUB: begin
            acc = acc - opnd;
            pc  = next2;
          end
          OP_MUL: begin
            acc = acc * opnd;
            pc  = next2;
          end
          OP_LOAD: begin
            acc = mem[opnd[ADDR_W-1:0]];
            pc  = next2;
          end
          OP_AD: begin
            acc = acc + mem[opnd[ADDR_W-1:0]];
            pc  = next2;
          end
          OP_BNZ: pc = (acc != '0) ? opnd[ADDR_W-1:0] : next2;
          default: st.illegal = 1'b1;
        endcase
      end
      st.acc_value    = acc;
      st.prog_counter = PC_OUT_W'(pc);
      st.halted       = stopped;
      pending_states.push_back(st);
    endfunction

    // Compare one result beat against the oldest queued state
    function void check_state(machine_state_t got);
      machine_state_t want;
      if (pending_states.size() == 0) begin
        $display("%0t: unexpected result beat: acc %h pc %0d", $time, got.acc_value,
                 got.prog_counter);
        errors++;
        return;
      end
      want = pending_states.pop_front();
      if (got.printed !== want.printed) begin
        $display("%0t: printed expected %b actual %b", $time, want.printed, got.printed);
        errors++;
      end
      if (got.acc_value !== want.acc_value) begin
        $display("%0t: acc_value expected %h actual %h", $time, want.acc_value,
                 got.acc_value);
        errors++;
      end
      if (got.prog_counter !== want.prog_counter) begin
        $display("%0t: prog_counter expected %0d actual %0d", $time, want.prog_counter,
                 got.prog_counter);
        errors++;
      end
      if (got.halted !== want.halted) begin
        $display("%0t: halted expected %b actual %b", $time, want.halted, got.halted);
        errors++;
      end
      if (got.illegal !== want.illegal) begin
        $display("%0t: illegal expected %b actual %b", $time, want.illegal, got.illegal);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  amc_in_if  in_ch ();
  amc_out_if out_ch ();

  accumulator_machine_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  acc_machine_mirror mirror;
  int items_sent  = 0;
  bit idle_on     = 1'b1;
  int stall_left  = 0;
  int cycle_count = 0;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Drop ready in random bursts while idling is on
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      out_ch.ready <= 1'b0;
      stall_left   <= $urandom_range(0, 5);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Check every result beat
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      mirror.check_state({out_ch.printed, out_ch.acc_value, out_ch.prog_counter,
                          out_ch.halted, out_ch.illegal});
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Present one beat, hold it until accepted, then advance the mirror
  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [IN_ADDR_W-1:0] address,
                           input logic [WORD_W-1:0] data);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.cmd     <= cmd;
    in_ch.address <= address;
    in_ch.data    <= data;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    mirror.note_item(cmd, address, data);
    items_sent++;
  endtask

  task automatic put_word(input logic [ADDR_W-1:0] address, input logic [WORD_W-1:0] word);
    send_item(CMD_WRITE, address, word);
  endtask

  task automatic fill_if_unwritten(input logic [ADDR_W-1:0] address);
    if (!mirror.written[address]) put_word(address, $urandom());
  endtask

  // Make sure every word the next instruction reads holds data, then execute it
  task automatic exec_step();
    logic [ADDR_W-1:0] at;
    logic [ADDR_W-1:0] nxt;
    logic [WORD_W-1:0] op;
    logic [WORD_W-1:0] opnd;
    at  = mirror.pc;
    nxt = at + 1'b1;
    fill_if_unwritten(at);
    fill_if_unwritten(nxt);
    op   = mirror.mem[at];
    opnd = mirror.mem[nxt];
    if (op == OP_LOAD || op == OP_AD) fill_if_unwritten(opnd[ADDR_W-1:0]);
    send_item(CMD_EXEC, IN_ADDR_W'($urandom()), $urandom());
  endtask

  function automatic logic [WORD_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return 32'd1;
      2: return '1;
      3: return 32'h7fff_ffff;
      4: return 32'h8000_0000;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [WORD_W-1:0] pick_opcode();
    case ($urandom_range(0, 19))
      0, 1:   return OP_ADD;
      2, 3:   return OP_SUB;
      4, 5:   return OP_MUL;
      6, 7:   return OP_LOAD;
      8, 9:   return OP_AD;
      10, 11: return OP_BNZ;
      12:     return OP_CLR;
      13:     return OP_NOP;
      14, 15: return OP_OUTPUT;
      16:     return OP_HALT;
      17:     return ILLEGAL_ABOVE;
      18:     return ILLEGAL_BELOW;
      default: return $urandom();
    endcase
  endfunction

  // Lay down a short random program; branches mostly land inside it
  task automatic write_program(input logic [ADDR_W-1:0] base, input int len);
    logic [ADDR_W-1:0] at;
    logic [WORD_W-1:0] op;
    logic [WORD_W-1:0] opnd;
    at = base;
    for (int i = 0; i < len; i++) begin
      op = (i == len - 1 && $urandom_range(0, 1) == 1) ? OP_HALT : pick_opcode();
      put_word(at, op);
      at++;
      if (op == OP_ADD || op == OP_SUB || op == OP_MUL || op == OP_LOAD || op == OP_AD ||
          op == OP_BNZ) begin
        if (op == OP_BNZ && $urandom_range(0, 3) != 0)
          opnd = WORD_W'(base) + $urandom_range(0, 2 * len - 1);
        else
          opnd = pick_value();
        put_word(at, opnd);
        at++;
      end
    end
  endtask

  initial begin
    logic [ADDR_W-1:0] base;
    int                len;
    int                steps;
    mirror        = new();
    in_ch.valid   = 1'b0;
    in_ch.cmd     = CMD_WRITE;
    in_ch.address = '0;
    in_ch.data    = '0;
    rst_n         = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: ADD, MUL, SUB, LOAD, AD, OUTPUT, CLR, BNZ, wrapping arithmetic, negative memory operand, unknown opcode
    put_word(11'd0, OP_ADD);
    put_word(11'd1, 32'h7fff_ffff);
    put_word(11'd2, OP_MUL);
    put_word(11'd3, 32'hffff_ffff);
    put_word(11'd4, OP_SUB);
    put_word(11'd5, 32'd2);
    put_word(11'd6, OP_LOAD);
    put_word(11'd7, 32'hffff_f81f);
    put_word(11'd31, 32'h8000_0000);
    put_word(11'd8, OP_AD);
    put_word(11'd9, 32'd31);
    put_word(11'd10, OP_OUTPUT);
    put_word(11'd11, OP_CLR);
    put_word(11'd12, OP_BNZ);
    put_word(11'd13, 32'd2046);
    put_word(11'd14, ILLEGAL_ABOVE);
    repeat (9) exec_step();

    // Directed: taken branch to the top of memory, pc wrap, halt, idle commands
    put_word(11'd14, OP_ADD);
    put_word(11'd15, 32'd5);
    put_word(11'd16, OP_BNZ);
    put_word(11'd17, 32'd2046);
    put_word(11'd2046, OP_NOP);
    put_word(11'd2047, OP_ADD);
    put_word(11'd1, OP_HALT);
    repeat (6) exec_step();
    send_item(CMD_UNUSED, '1, '1);
    send_item(CMD_RESTART, '0, '0);

    // Random: restart, load a program, step through it with some noise mixed in
    while (items_sent < ITEM_TARGET) begin
      if (items_sent > ITEM_TARGET - QUIET_TAIL) idle_on = 1'b0;
      send_item(CMD_RESTART, IN_ADDR_W'($urandom()), $urandom());
      len  = $urandom_range(3, 12);
      base = '0;
      if ($urandom_range(0, 3) == 0) begin
        base = ADDR_W'($urandom());
        put_word(11'd0, OP_ADD);
        put_word(11'd1, $urandom() | 32'd1);
        put_word(11'd2, OP_BNZ);
        put_word(11'd3, WORD_W'(base));
      end
      write_program(base, len);
      steps = $urandom_range(len, 3 * len);
      for (int s = 0; s < steps; s++) begin
        case ($urandom_range(0, 23))
          0: send_item(CMD_UNUSED, IN_ADDR_W'($urandom()), $urandom());
          1: put_word(ADDR_W'($urandom()), $urandom());
          2: send_item(CMD_RESTART, IN_ADDR_W'($urandom()), $urandom());
          default: exec_step();
        endcase
      end
    end

    // Drain outstanding results
    in_ch.valid <= 1'b0;
    while (mirror.pending_states.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mirror.errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

>>> sim.f
rtl/core/amc_pkg.sv
rtl/core/amc_if.sv
rtl/core/amc_word_mem.sv
rtl/core/accumulator_machine_core.sv
test/tb_top.sv
